/* rtl/core/phlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package phlp_pkg;

  localparam int unsigned PosW = 7;

  localparam logic [PosW-1:0] PosMax       = 7'd127;
  localparam logic [PosW-1:0] PosTypeHi    = 7'd12;
  localparam logic [PosW-1:0] PosTypeLo    = 7'd13;
  localparam logic [PosW-1:0] PosIhl       = 7'd14;
  localparam logic [PosW-1:0] PosProto     = 7'd23;
  localparam logic [PosW-1:0] TcpOffPos    = 7'd26;  // 14 byte L2 header + 12

  localparam logic [15:0] EthLen     = 16'd14;
  localparam logic [15:0] NonIpLen   = 16'd42;
  localparam logic [15:0] MinIpEnd   = 16'd34;
  localparam logic [15:0] UdpLen     = 16'd8;
  localparam logic [15:0] TcpOffByte = 16'd12;
  localparam logic [15:0] Ipv4Type   = 16'h0800;

  localparam logic [7:0] ProtoIcmp = 8'h01;
  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoUdp  = 8'h11;

  typedef enum logic [3:0] {
    ClsShortL2   = 4'd0,
    ClsNonIpv4   = 4'd1,
    ClsShortIp   = 4'd2,
    ClsTruncIp   = 4'd3,
    ClsIcmp      = 4'd4,
    ClsUdp       = 4'd5,
    ClsTcpTrunc  = 4'd6,
    ClsTcp       = 4'd7,
    ClsOther     = 4'd8
  } hdr_class_e;

  // Header fields of one finished packet, handed from capture to classify
  typedef struct packed {
    logic [15:0] ether_type;
    logic [3:0]  ip_words;
    logic [7:0]  ip_proto;
    logic [3:0]  tcp_words;
    logic [15:0] pkt_len;
  } hdr_snap_t;

endpackage

`default_nettype wire

/* rtl/core/phlp_capture.sv */
`timescale 1ns / 1ps
`default_nettype none

module phlp_capture import phlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] packet_length_i,
  input  wire logic        last_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output hdr_snap_t        snap_o,
  output logic             snap_valid_o,
  input  wire logic        snap_ready_i
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     etype_q, etype_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [7:0]      proto_q, proto_d;
  logic [3:0]      tcpw_q, tcpw_d;
  logic [PosW-1:0] tcp_pos;
  logic            accept;
  logic            snap_valid_q;
  hdr_snap_t       snap_q;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tcp_pos    = TcpOffPos + {1'b0, ihl_q, 2'b00};

  always_comb begin
    etype_d = etype_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    tcpw_d  = tcpw_q;
    priority if (pos_q == PosTypeHi) begin
      etype_d[15:8] = data_byte_i;
    end else if (pos_q == PosTypeLo) begin
      etype_d[7:0] = data_byte_i;
    end else if (pos_q == PosIhl) begin
      ihl_d = data_byte_i[3:0];
    end else if (pos_q == PosProto) begin
      proto_d = data_byte_i;
    end
    if (pos_q == tcp_pos && pos_q > PosIhl) begin
      tcpw_d = data_byte_i[7:4];
    end
    pos_d = (pos_q < PosMax) ? pos_q + 7'd1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      etype_q      <= '0;
      ihl_q        <= '0;
      proto_q      <= '0;
      tcpw_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (accept && last_byte_i) begin
        // last byte counts too, then state returns to its reset values
        pos_q        <= '0;
        etype_q      <= '0;
        ihl_q        <= '0;
        proto_q      <= '0;
        tcpw_q       <= '0;
        snap_valid_q <= 1'b1;
      end else begin
        if (accept) begin
          pos_q   <= pos_d;
          etype_q <= etype_d;
          ihl_q   <= ihl_d;
          proto_q <= proto_d;
          tcpw_q  <= tcpw_d;
        end
        if (snap_ready_i) begin
          snap_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      snap_q.ether_type <= etype_d;
      snap_q.ip_words   <= ihl_d;
      snap_q.ip_proto   <= proto_d;
      snap_q.tcp_words  <= tcpw_d;
      snap_q.pkt_len    <= packet_length_i;
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;

endmodule

`default_nettype wire

/* rtl/core/phlp_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module phlp_classify import phlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  hdr_snap_t        snap_i,
  input  wire logic        snap_valid_i,
  output logic             snap_ready_o,
  output logic [15:0]      header_length_o,
  output logic [3:0]       header_class_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  logic [15:0] total;
  logic [15:0] hl_d;
  hdr_class_e  cls_d;
  logic [15:0] hl_q;
  hdr_class_e  cls_q;
  logic        out_valid_q;
  logic        load;

  assign total = EthLen + {10'd0, snap_i.ip_words, 2'b00};

  always_comb begin
    priority if (snap_i.pkt_len < EthLen) begin
      hl_d  = EthLen;
      cls_d = ClsShortL2;
    end else if (snap_i.ether_type != Ipv4Type) begin
      hl_d  = NonIpLen;
      cls_d = ClsNonIpv4;
    end else if (snap_i.pkt_len < MinIpEnd) begin
      hl_d  = MinIpEnd;
      cls_d = ClsShortIp;
    end else if (snap_i.pkt_len < total) begin
      hl_d  = snap_i.pkt_len;
      cls_d = ClsTruncIp;
    end else if (snap_i.ip_proto == ProtoIcmp) begin
      hl_d  = NonIpLen;
      cls_d = ClsIcmp;
    end else if (snap_i.ip_proto == ProtoUdp) begin
      hl_d  = total + UdpLen;
      cls_d = ClsUdp;
    end else if (snap_i.ip_proto == ProtoTcp) begin
      if (snap_i.pkt_len <= total + TcpOffByte) begin
        hl_d  = total;
        cls_d = ClsTcpTrunc;
      end else begin
        hl_d  = total + {10'd0, snap_i.tcp_words, 2'b00};
        cls_d = ClsTcp;
      end
    end else begin
      hl_d  = total;
      cls_d = ClsOther;
    end
  end

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hl_q  <= hl_d;
      cls_q <= cls_d;
    end
  end

  assign header_length_o = hl_q;
  assign header_class_o  = cls_q;
  assign out_valid_o     = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/packet_header_length_parser_unit.sv */
// Capture header length parser for Ethernet / IPv4 / TCP / UDP frames.
//
// Input channel (in_valid_i / in_ready_o): one packet byte per transfer, in
// wire order from the first Ethernet header byte, with the packet length and
// a last-byte mark. Only a transfer with last_byte_i set produces a result.
// Output channel (out_valid_o / out_ready_i): header_length_o and
// header_class_o for each finished packet.
//
// Throughput: one byte per cycle unless the snapshot and result registers are
// both full. The field capture is one compare stage against the running byte
// position, so bytes stream with no gaps until then. The snapshot register
// takes the packet at the last byte's transfer, and the result register takes
// it from there once free; out_valid_o then rises.
//
// Reset clears the byte position, the captured fields and both valid flags;
// no packet is in progress afterward. When the receiver stalls, the result
// register holds its value and the snapshot stage still takes one more
// finished packet; input backs up only once both are full.
`timescale 1ns / 1ps
`default_nettype none

module packet_header_length_parser_unit import phlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] packet_length_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      header_length_o,
  output logic [3:0]       header_class_o
);

  hdr_snap_t snap;
  logic      snap_valid;
  logic      snap_ready;

  phlp_capture u_capture (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .packet_length_i (packet_length_i),
    .last_byte_i     (last_byte_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .snap_o          (snap),
    .snap_valid_o    (snap_valid),
    .snap_ready_i    (snap_ready)
  );

  phlp_classify u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_i          (snap),
    .snap_valid_i    (snap_valid),
    .snap_ready_o    (snap_ready),
    .header_length_o (header_length_o),
    .header_class_o  (header_class_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule

`default_nettype wire

/* bench/tb_packet_header_length_parser_unit.sv */
`timescale 1ns / 1ps

module tb_packet_header_length_parser_unit;
  import phlp_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        last;
  } frame_byte_t;

  typedef struct packed {
    logic [15:0] hdr_len;
    hdr_class_e  cls;
  } hdr_result_t;

  typedef enum logic [1:0] {
    RdyOpen,
    RdyCoin,
    RdySparse,
    RdyToggle
  } rdy_mode_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i     = '0;
  logic [15:0] packet_length_i = '0;
  logic        last_byte_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [15:0] header_length_o;
  logic [3:0]  header_class_o;

  frame_byte_t frame_byte_q[$];
  hdr_result_t hdr_result_q[$];
  logic [7:0]  frame_buf[$];

  // tracked parser state
  logic [6:0]  trk_pos   = '0;
  logic [15:0] trk_type  = '0;
  logic [3:0]  trk_ihl   = '0;
  logic [7:0]  trk_proto = '0;
  logic [3:0]  trk_doff  = '0;

  int unsigned errors       = 0;
  int unsigned frames_built = 0;
  int unsigned bytes_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned class_hits[9];

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  rdy_mode_e   rdy_mode   = RdyOpen;
  int unsigned rdy_span   = 0;
  hdr_result_t got_want;

  packet_header_length_parser_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .packet_length_i(packet_length_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .header_length_o(header_length_o),
    .header_class_o (header_class_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Capture one byte into the tracked state; on the last byte, work out the
  // header length and class and clear for the next frame.
  function automatic void track_byte(frame_byte_t fb);
    logic [6:0]  tcp_at;
    int unsigned len;
    int unsigned l3_end;
    hdr_result_t r;
    tcp_at = TcpOffPos + 7'({trk_ihl, 2'b00});
    case (trk_pos)
      PosTypeHi: trk_type[15:8] = fb.data;
      PosTypeLo: trk_type[7:0] = fb.data;
      PosIhl:    trk_ihl = fb.data[3:0];
      PosProto:  trk_proto = fb.data;
      default: ;
    endcase
    if (trk_pos == tcp_at && trk_pos > PosIhl) trk_doff = fb.data[7:4];
    if (trk_pos != PosMax) trk_pos = trk_pos + 7'd1;
    bytes_taken++;
    if (fb.last) begin
      len = fb.len;
      l3_end = EthLen + 4 * trk_ihl;
      if (len < EthLen) begin
        r.hdr_len = EthLen;
        r.cls = ClsShortL2;
      end else if (trk_type != Ipv4Type) begin
        r.hdr_len = NonIpLen;
        r.cls = ClsNonIpv4;
      end else if (len < MinIpEnd) begin
        r.hdr_len = MinIpEnd;
        r.cls = ClsShortIp;
      end else if (len < l3_end) begin
        r.hdr_len = 16'(len);
        r.cls = ClsTruncIp;
      end else if (trk_proto == ProtoIcmp) begin
        r.hdr_len = NonIpLen;
        r.cls = ClsIcmp;
      end else if (trk_proto == ProtoUdp) begin
        r.hdr_len = 16'(l3_end + UdpLen);
        r.cls = ClsUdp;
      end else if (trk_proto == ProtoTcp) begin
        if (len <= l3_end + TcpOffByte) begin
          r.hdr_len = 16'(l3_end);
          r.cls = ClsTcpTrunc;
        end else begin
          r.hdr_len = 16'(l3_end + 4 * trk_doff);
          r.cls = ClsTcp;
        end
      end else begin
        r.hdr_len = 16'(l3_end);
        r.cls = ClsOther;
      end
      hdr_result_q.push_back(r);
      class_hits[r.cls]++;
      trk_pos = '0;
      trk_type = '0;
      trk_ihl = '0;
      trk_proto = '0;
      trk_doff = '0;
    end
  endfunction

  // Turn frame_buf into byte transfers; non-last bytes sometimes carry a junk
  // length, which the block must ignore.
  task automatic queue_frame(input logic [15:0] len);
    frame_byte_t fb;
    for (int i = 0; i < frame_buf.size(); i++) begin
      fb.data = frame_buf[i];
      fb.last = (i == frame_buf.size() - 1);
      fb.len = (fb.last || $urandom_range(0, 7) != 0) ? len : 16'($urandom);
      frame_byte_q.push_back(fb);
    end
    frames_built++;
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      data_byte_i     <= '0;
      packet_length_i <= '0;
      last_byte_i     <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) track_byte(frame_byte_q.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (frame_byte_q.size() > 0) begin
        in_valid_i      <= 1'b1;
        data_byte_i     <= frame_byte_q[0].data;
        packet_length_i <= frame_byte_q[0].len;
        last_byte_i     <= frame_byte_q[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready pattern switches between modes at random intervals
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rdy_mode = RdyOpen;
      rdy_span = 0;
    end else begin
      if (rdy_span == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        rdy_span = $urandom_range(16, 96);
      end else begin
        rdy_span--;
      end
      case (rdy_mode)
        RdyOpen:   out_ready_i <= 1'b1;
        RdyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        RdySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // Result check against the oldest expected header
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (hdr_result_q.size() == 0) begin
        $display("%0t: unexpected result: length %0d class %0d", $time,
                 header_length_o, header_class_o);
        errors++;
      end else begin
        got_want = hdr_result_q.pop_front();
        if (header_length_o !== got_want.hdr_len) begin
          $display("%0t: header_length mismatch: expected %0d actual %0d", $time,
                   got_want.hdr_len, header_length_o);
          errors++;
        end
        if (header_class_o !== got_want.cls) begin
          $display("%0t: header_class mismatch: expected %0d actual %0d", $time,
                   got_want.cls, header_class_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
             IdleLimit, hdr_result_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned shape;
    int unsigned n;
    int unsigned full;
    int unsigned l3_end;
    int unsigned tcp_at;
    int          len_tmp;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [15:0] len;

    // directed: short frames and lengths that disagree with the bytes seen
    frame_buf = '{8'h5a};
    queue_frame(16'd0);
    frame_buf = '{8'hff};
    queue_frame(16'd13);
    frame_buf = '{8'h00};
    queue_frame(16'd14);
    frame_buf = '{8'hff};
    queue_frame(16'hffff);
    frame_buf = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    queue_frame(16'd20);
    frame_buf.delete();
    repeat (14) frame_buf.push_back(8'h00);
    frame_buf[12] = Ipv4Type[15:8];
    frame_buf[13] = Ipv4Type[7:0];
    queue_frame(16'd33);

    // random frames, mostly well-formed IPv4 with random content
    while (frame_byte_q.size() < 1700) begin
      shape = $urandom_range(0, 9);
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(5, 15));
      case ($urandom_range(0, 4))
        0:       proto = ProtoIcmp;
        1:       proto = ProtoUdp;
        2, 3:    proto = ProtoTcp;
        default: proto = 8'($urandom);
      endcase
      l3_end = EthLen + 4 * ihl;
      tcp_at = TcpOffPos + 4 * ihl;
      full = l3_end + $urandom_range(0, 24);
      if (proto == ProtoTcp) full += 4 * doff;
      else if (proto == ProtoUdp) full += UdpLen;
      if (shape == 0) n = $urandom_range(1, 20);
      else if (shape == 1) n = $urandom_range(full, full + 80);  // may pass 127
      else if (shape == 2) n = $urandom_range(1, full);
      else n = full;

      frame_buf.delete();
      repeat (n) frame_buf.push_back(8'($urandom));
      // shape 3 keeps a random EtherType
      if (shape != 3) begin
        if (n > PosTypeHi) frame_buf[PosTypeHi] = Ipv4Type[15:8];
        if (n > PosTypeLo) frame_buf[PosTypeLo] = Ipv4Type[7:0];
        if (n > PosIhl) frame_buf[PosIhl] = {4'h4, ihl};
        if (n > PosProto) frame_buf[PosProto] = proto;
        if (n > tcp_at) frame_buf[tcp_at] = {doff, 4'($urandom)};
      end

      case ($urandom_range(0, 9))
        0:       len = 16'($urandom);
        1: begin
          len_tmp = int'(n) + int'($urandom_range(0, 40)) - 20;
          len = (len_tmp < 0) ? 16'd0 : 16'(len_tmp);
        end
        default: len = 16'(n);
      endcase
      queue_frame(len);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (frame_byte_q.size() == 0 && !in_valid_i);
    wait (hdr_result_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d frames (%0d bytes), checked %0d header results.", frames_built,
             bytes_taken, results_seen);
    $display("Per class 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d", class_hits[0],
             class_hits[1], class_hits[2], class_hits[3], class_hits[4], class_hits[5],
             class_hits[6], class_hits[7], class_hits[8]);
    if (errors == 0 && hdr_result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
